// ===== hdl/clc_pkg.sv =====
package clc_pkg;

  localparam int unsigned NumRows     = 5;
  localparam int unsigned NumDataRows = 4;
  localparam int unsigned RowW        = 8;
  localparam int unsigned SynW        = 3;
  localparam int unsigned DataW       = 16;
  localparam int unsigned CodeW       = NumRows * RowW;

  localparam logic CmdEncode = 1'b0;
  localparam logic CmdDecode = 1'b1;

  typedef logic [RowW-1:0] row_t;
  typedef logic [SynW-1:0] syn_t;

  // row 0 sits in the top byte, same order as the codeword
  typedef struct packed {
    logic                    enc;
    logic [0:NumRows-1][RowW-1:0] rows;
  } word_t;

  // what one correction pass learns from the rows before touching them
  typedef struct packed {
    word_t                        word;
    logic [0:NumDataRows-1][SynW-1:0] syn;
    logic [0:NumDataRows-1]       par;
    row_t                         col;
    logic                         one_bad;
  } scan_t;

  function automatic row_t encode_row(input logic [3:0] nib);
    logic c3;
    logic c2;
    logic c1;
    c3 = nib[3] ^ nib[2] ^ nib[0];
    c2 = nib[3] ^ nib[1] ^ nib[0];
    c1 = nib[2] ^ nib[1] ^ nib[0];
    return {nib, c3, c2, c1, ^{nib, c3, c2, c1}};
  endfunction

  function automatic syn_t row_syn(input row_t r);
    logic s0;
    logic s1;
    logic s2;
    s0 = r[7] ^ r[6] ^ r[4] ^ r[3];
    s1 = r[7] ^ r[5] ^ r[4] ^ r[2];
    s2 = r[6] ^ r[5] ^ r[4] ^ r[1];
    return {s2, s1, s0};
  endfunction

  // hamming single-error position for a row syndrome
  function automatic row_t single_bit(input syn_t s);
    row_t m;
    case (s)
      3'b001:  m = 8'h08;
      3'b010:  m = 8'h04;
      3'b100:  m = 8'h02;
      3'b111:  m = 8'h10;
      3'b110:  m = 8'h20;
      3'b101:  m = 8'h40;
      3'b011:  m = 8'h80;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/clc_pass.sv =====
module clc_pass (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  clc_pkg::word_t in_word,
  output logic           out_valid,
  input  logic           out_ready,
  output clc_pkg::word_t out_word
);

  logic            scan_valid_r;
  clc_pkg::scan_t  scan_r;
  clc_pkg::scan_t  scan_nxt;
  logic            fix_valid_r;
  clc_pkg::word_t  fix_r;
  clc_pkg::word_t  fix_nxt;
  logic            fix_ready;
  logic            scan_ready;

  assign fix_ready  = !fix_valid_r || out_ready;
  assign scan_ready = !scan_valid_r || fix_ready;
  assign in_ready   = scan_ready;
  assign out_valid  = fix_valid_r;
  assign out_word   = fix_r;

  // first half: column syndrome, row syndromes, parity, single-bad-row flag
  always_comb begin
    logic [clc_pkg::NumRows-1:0] bad;
    clc_pkg::syn_t               s;
    scan_nxt      = '0;
    scan_nxt.word = in_word;
    bad           = '0;
    for (int i = 0; i < clc_pkg::NumRows; i++) begin
      scan_nxt.col = scan_nxt.col ^ in_word.rows[i];
      s            = clc_pkg::row_syn(in_word.rows[i]);
      bad[i]       = (s != '0) || (^in_word.rows[i]);
      if (i < clc_pkg::NumDataRows) begin
        scan_nxt.syn[i] = s;
        scan_nxt.par[i] = ^in_word.rows[i];
      end
    end
    scan_nxt.one_bad = (bad != '0) && ((bad & (bad - 1'b1)) == '0);
  end

  // second half: apply the corrections to the data rows of decode words, row 4 untouched; encode words pass through
  always_comb begin
    logic          syn_nz;
    logic          p;
    clc_pkg::row_t mask;
    fix_nxt = scan_r.word;
    for (int i = 0; i < clc_pkg::NumDataRows; i++) begin
      syn_nz = (scan_r.syn[i] != '0);
      p      = scan_r.par[i];
      if (scan_r.one_bad && syn_nz) begin
        mask = scan_r.col;
      end else if (p && !syn_nz) begin
        mask = scan_r.col;
      end else if (syn_nz && !p) begin
        mask = scan_r.col;
      end else if (syn_nz) begin
        mask = clc_pkg::single_bit(scan_r.syn[i]);
      end else begin
        mask = '0;
      end
      if (!scan_r.word.enc) begin
        fix_nxt.rows[i] = scan_r.word.rows[i] ^ mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_valid_r <= 1'b0;
      fix_valid_r  <= 1'b0;
    end else begin
      if (scan_ready) begin
        scan_valid_r <= in_valid;
      end
      if (fix_ready) begin
        fix_valid_r <= scan_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_ready && in_valid) begin
      scan_r <= scan_nxt;
    end
    if (fix_ready && scan_valid_r) begin
      fix_r <= fix_nxt;
    end
  end

endmodule

// ===== hdl/column_line_code_ecc_codec_top.sv =====
// column line code ecc codec for a 16-bit word
//
// input channel: in_valid / in_stall with in_cmd, in_data_in and in_codeword_in.
// in_cmd low encodes in_data_in into a 40-bit codeword (four hamming rows plus a
// column parity row); in_cmd high decodes in_codeword_in with two correction
// passes and returns the corrected 16-bit word.
// result channel: out_valid / out_stall with out_data_out and out_codeword_out;
// the field that the command does not produce reads as zero.
//
// pipeline: input register, two stages per correction pass, output register.
// a transfer passes through each of these in order before it shows on out_valid.
// throughput is one item per cycle while out_stall is low; every stage advances
// when it is empty or the stage after it moves, so bubbles close up under a stall.
// when the receiver holds out_stall the pipeline fills, then in_stall rises;
// nothing is dropped or repeated and the held result stays on the ports.
// reset (synchronous, rst_n low) empties every stage; payload is not cleared.
module column_line_code_ecc_codec_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [clc_pkg::DataW-1:0]   in_data_in,
  input  logic [clc_pkg::CodeW-1:0]   in_codeword_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [clc_pkg::DataW-1:0]   out_data_out,
  output logic [clc_pkg::CodeW-1:0]   out_codeword_out
);

  logic                      s1_valid_r;
  clc_pkg::word_t            s1_r;
  clc_pkg::word_t            s1_nxt;
  logic                      s1_ready;

  logic                      p1_in_ready;
  logic                      p1_out_valid;
  clc_pkg::word_t            p1_out_word;
  logic                      p2_in_ready;
  logic                      p2_out_valid;
  clc_pkg::word_t            p2_out_word;

  logic                      out_valid_r;
  logic                      out_ready;
  logic [clc_pkg::DataW-1:0] data_out_r;
  logic [clc_pkg::DataW-1:0] data_out_nxt;
  logic [clc_pkg::CodeW-1:0] codeword_out_r;
  logic [clc_pkg::CodeW-1:0] codeword_out_nxt;

  assign s1_ready = !s1_valid_r || p1_in_ready;
  assign in_stall = !s1_ready;

  // encode is cheap enough to finish in the input stage
  always_comb begin
    s1_nxt     = '0;
    s1_nxt.enc = (in_cmd == clc_pkg::CmdEncode);
    if (in_cmd == clc_pkg::CmdEncode) begin
      for (int i = 0; i < clc_pkg::NumDataRows; i++) begin
        s1_nxt.rows[i] = clc_pkg::encode_row(
          in_data_in[clc_pkg::DataW-1-4*i -: 4]);
        s1_nxt.rows[clc_pkg::NumDataRows] = s1_nxt.rows[clc_pkg::NumDataRows] ^
                                            s1_nxt.rows[i];
      end
    end else begin
      s1_nxt.rows = in_codeword_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  clc_pass u_pass1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (p1_in_ready),
    .in_word   (s1_r),
    .out_valid (p1_out_valid),
    .out_ready (p2_in_ready),
    .out_word  (p1_out_word)
  );

  clc_pass u_pass2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p1_out_valid),
    .in_ready  (p2_in_ready),
    .in_word   (p1_out_word),
    .out_valid (p2_out_valid),
    .out_ready (out_ready),
    .out_word  (p2_out_word)
  );

  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    data_out_nxt     = '0;
    codeword_out_nxt = '0;
    if (p2_out_word.enc) begin
      codeword_out_nxt = p2_out_word.rows;
    end else begin
      for (int i = 0; i < clc_pkg::NumDataRows; i++) begin
        data_out_nxt[clc_pkg::DataW-1-4*i -: 4] = p2_out_word.rows[i][7:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= p2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && p2_out_valid) begin
      data_out_r     <= data_out_nxt;
      codeword_out_r <= codeword_out_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_out     = data_out_r;
  assign out_codeword_out = codeword_out_r;

  // only one of the two result fields is ever in use
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (codeword_out_r == '0 || data_out_r == '0))
    else $error("both result fields nonzero");

  // the column parity row makes every emitted codeword xor to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((codeword_out_r[39:32] ^ codeword_out_r[31:24] ^
                      codeword_out_r[23:16] ^ codeword_out_r[15:8] ^
                      codeword_out_r[7:0]) == 8'h00))
    else $error("codeword column parity broken");

  // input back-pressure only when the first stage holds an item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty first stage");

  // a held result is not overwritten while the receiver stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(codeword_out_r) &&
                                    $stable(data_out_r)))
    else $error("stalled result changed");

  assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule
